// ===== rtl/ppf_pkg.sv =====
package ppf_pkg;

   // Fixed field and register widths.
   localparam int SampleW      = 32;
   localparam int CoefW        = 32;
   localparam int RegW         = 64;
   localparam int NumRegs      = 5;
   localparam int NumCoefs     = 9;
   localparam int CsrAddrW     = 6;
   localparam int RegSelLsb    = 3;
   localparam int PatchIndexW  = 8;

   // Default filter configuration.
   localparam int DefaultOrder   = 4;
   localparam int DefaultPatches = 256;

   // Arithmetic: Q16.16 samples times Q4.28 coefficients give Q20.44 products.
   localparam int ProdW     = 64;
   localparam int AccW      = 68;
   localparam int FracShift = 28;

   localparam logic [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};
   localparam logic [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};

   // Coefficient order: b0..b4, then a1..a4.
   localparam int FeedbackBase = 5;

   typedef logic [NumCoefs-1:0][CoefW-1:0] coef_set_type;

   typedef enum logic [2:0] {
      RegB0B1 = 3'd0,
      RegB2B3 = 3'd1,
      RegB4A1 = 3'd2,
      RegA2A3 = 3'd3,
      RegA4   = 3'd4
   } reg_index_type;

   // b0 resets to 1.0 in Q4.28; every other coefficient resets to zero.
   localparam logic [RegW-1:0] RegReset [NumRegs] = '{
      64'd268435456, 64'd0, 64'd0, 64'd0, 64'd0
   };

endpackage

// ===== rtl/ppf_ram.sv =====
module ppf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ppf_regs.sv =====
module ppf_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ppf_pkg::CsrAddrW-1:0]     paddr,
   input  logic [ppf_pkg::RegW-1:0]         pwdata,
   output logic [ppf_pkg::RegW-1:0]         prdata,
   output ppf_pkg::coef_set_type            coefs
);

   logic [ppf_pkg::RegW-1:0] regs_ff [ppf_pkg::NumRegs];
   logic [ppf_pkg::RegW-1:0] regs_in [ppf_pkg::NumRegs];
   ppf_pkg::reg_index_type   sel;
   logic                     wr;

   assign sel = ppf_pkg::reg_index_type'(paddr[ppf_pkg::CsrAddrW-1:ppf_pkg::RegSelLsb]);
   assign wr  = psel && penable && pwrite;

   always_comb begin
      regs_in = regs_ff;
      if (wr) begin
         unique case (sel)
            ppf_pkg::RegB0B1, ppf_pkg::RegB2B3, ppf_pkg::RegB4A1, ppf_pkg::RegA2A3: begin
               regs_in[sel] = pwdata;
            end
            ppf_pkg::RegA4: begin
               regs_in[sel] = {{(ppf_pkg::RegW-ppf_pkg::CoefW){1'b0}},
                               pwdata[ppf_pkg::CoefW-1:0]};
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         ppf_pkg::RegB0B1, ppf_pkg::RegB2B3, ppf_pkg::RegB4A1, ppf_pkg::RegA2A3,
         ppf_pkg::RegA4: begin
            prdata = regs_ff[sel];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ppf_pkg::NumRegs; i++) begin
            regs_ff[i] <= ppf_pkg::RegReset[i];
         end
      end else begin
         regs_ff <= regs_in;
      end
   end

   // Two coefficients per register, the even one in the low half; the last register holds only a4.
   always_comb begin
      for (int n = 0; n < ppf_pkg::NumCoefs; n++) begin
         coefs[n] = (n % 2 == 1) ? regs_ff[n >> 1][ppf_pkg::RegW-1:ppf_pkg::CoefW]
                                 : regs_ff[n >> 1][ppf_pkg::CoefW-1:0];
      end
   end

endmodule

// ===== rtl/ppf_filter.sv =====
module ppf_filter #(
   parameter int ORDER = ppf_pkg::DefaultOrder
) (
   input  logic                                  restart,
   input  logic signed [ppf_pkg::SampleW-1:0]    x,
   input  logic [2*ORDER*ppf_pkg::SampleW-1:0]   hist_row,
   input  ppf_pkg::coef_set_type                 coefs,
   output logic [ppf_pkg::SampleW-1:0]           y,
   output logic                                  sat,
   output logic [2*ORDER*ppf_pkg::SampleW-1:0]   next_row
);

   localparam int SW = ppf_pkg::SampleW;
   localparam logic signed [ppf_pkg::AccW-1:0] Half =
      ppf_pkg::AccW'(1) << (ppf_pkg::FracShift - 1);

   logic signed [SW-1:0]                xh [ORDER];
   logic signed [SW-1:0]                yh [ORDER];
   logic signed [ppf_pkg::ProdW-1:0]    prod_b [ORDER+1];
   logic signed [ppf_pkg::ProdW-1:0]    prod_a [ORDER];
   logic signed [ppf_pkg::AccW-1:0]     acc;
   logic signed [ppf_pkg::AccW-1:0]     rounded;
   logic [ppf_pkg::AccW-ppf_pkg::FracShift-SW:0] upper;

   // Entry 0 of each history is the newest; restart reads as empty history.
   always_comb begin
      for (int k = 0; k < ORDER; k++) begin
         xh[k] = restart ? '0 : hist_row[SW*k +: SW];
         yh[k] = restart ? '0 : hist_row[SW*(ORDER+k) +: SW];
      end
   end

   always_comb begin
      prod_b[0] = $signed(coefs[0]) * x;
      for (int k = 0; k < ORDER; k++) begin
         prod_b[k+1] = $signed(coefs[k+1]) * xh[k];
         prod_a[k]   = $signed(coefs[ppf_pkg::FeedbackBase+k]) * yh[k];
      end
   end

   // The exact sum never overflows: nine terms of at most 2^62 each.
   always_comb begin
      acc = ppf_pkg::AccW'(prod_b[0]);
      for (int k = 0; k < ORDER; k++) begin
         acc = acc + ppf_pkg::AccW'(prod_b[k+1]) - ppf_pkg::AccW'(prod_a[k]);
      end
      rounded = acc + Half;
   end

   // The rounded result fits when all bits above its sign bit agree with it.
   assign upper = rounded[ppf_pkg::AccW-1:ppf_pkg::FracShift+SW-1];
   assign sat   = !((&upper) || !(|upper));

   always_comb begin
      if (sat) begin
         y = rounded[ppf_pkg::AccW-1] ? ppf_pkg::SampleMin : ppf_pkg::SampleMax;
      end else begin
         y = rounded[ppf_pkg::FracShift +: SW];
      end
   end

   always_comb begin
      next_row[0 +: SW]         = x;
      next_row[SW*ORDER +: SW]  = y;
      for (int k = 1; k < ORDER; k++) begin
         next_row[SW*k +: SW]         = xh[k-1];
         next_row[SW*(ORDER+k) +: SW] = yh[k-1];
      end
   end

endmodule

// ===== rtl/per_patch_iir_pressure_filter_core.sv =====
// Order-4 direct-form-I IIR filter with a private input and output history for
// each surface patch. The core accepts one item per clock while results are
// taken and no clear is running. The accepting edge registers the item and reads
// the patch history from a memory with one row per patch; the result register is
// then loaded, once it is free or being taken, after the nine multiplies, the
// exact sum, round-half-up to Q16.16 and saturation. A sample that directly
// follows one for the same patch takes the history just produced from a
// forwarding register, so back-to-back items on one patch also run at one per
// clock. After reset the history memory is cleared one row per clock, all PATCHES
// rows (256 by default), with req_ready low; coefficient writes are taken then
// too. Coefficients sit at byte addresses 0, 8, 16, 24 and 32.
module per_patch_iir_pressure_filter_core #(
   parameter int ORDER   = ppf_pkg::DefaultOrder,
   parameter int PATCHES = ppf_pkg::DefaultPatches
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ppf_pkg::PatchIndexW-1:0]     req_patch_index,
   input  logic signed [ppf_pkg::SampleW-1:0]  req_pressure_in,
   input  logic                                req_restart,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ppf_pkg::SampleW-1:0]  rsp_pressure_out,
   output logic                                rsp_saturated,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ppf_pkg::CsrAddrW-1:0]        csr_paddr,
   input  logic [ppf_pkg::RegW-1:0]            csr_pwdata,
   output logic [ppf_pkg::RegW-1:0]            csr_prdata,
   output logic                                csr_pready
);

   localparam int PatchW   = (PATCHES > 1) ? $clog2(PATCHES) : 1;
   localparam int RowW     = 2 * ORDER * ppf_pkg::SampleW;
   localparam int IndexNum = 2 ** ppf_pkg::PatchIndexW;

   ppf_pkg::coef_set_type coefs;

   logic [PatchW-1:0] req_patch;

   logic                             clr_busy_ff, clr_busy_in;
   logic [PatchW-1:0]                clr_addr_ff, clr_addr_in;

   logic                             s1_valid_ff, s1_valid_in;
   logic [PatchW-1:0]                s1_patch_ff;
   logic signed [ppf_pkg::SampleW-1:0] s1_x_ff;
   logic                             s1_restart_ff;

   logic                             fwd_valid_ff, fwd_valid_in;
   logic [PatchW-1:0]                fwd_patch_ff;
   logic [RowW-1:0]                  fwd_row_ff;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ppf_pkg::SampleW-1:0]      rsp_pressure_out_ff;
   logic                             rsp_saturated_ff;

   logic                             req_fire;
   logic                             s1_fire;
   logic                             fwd_hit;
   logic [RowW-1:0]                  ram_rd_data;
   logic [RowW-1:0]                  hist_row;
   logic [RowW-1:0]                  next_row;
   logic [ppf_pkg::SampleW-1:0]      y;
   logic                             sat;
   logic                             ram_wr_en;
   logic [PatchW-1:0]                ram_wr_addr;
   logic [RowW-1:0]                  ram_wr_data;

   // Patch index modulo PATCHES, through a constant lookup when PATCHES is below the index range.
   generate
      if (PATCHES >= IndexNum) begin : g_patch_direct
         assign req_patch = PatchW'(req_patch_index);
      end else begin : g_patch_mod
         logic [PatchW-1:0] mod_lut [IndexNum];
         for (genvar i = 0; i < IndexNum; i++) begin : g_lut
            assign mod_lut[i] = PatchW'(i % PATCHES);
         end
         assign req_patch = mod_lut[req_patch_index];
      end
   endgenerate

   ppf_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .coefs   (coefs)
   );

   assign csr_pready = 1'b1;

   // Handshake and stage advance.
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clr_busy_ff && (!s1_valid_ff || s1_fire);
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_ready);
   assign fwd_valid_in = fwd_valid_ff || s1_fire;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + PatchW'(1);
         if (clr_addr_ff == PatchW'(PATCHES - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_patch_ff   <= req_patch;
         s1_x_ff       <= req_pressure_in;
         s1_restart_ff <= req_restart;
      end
      if (s1_fire) begin
         fwd_patch_ff        <= s1_patch_ff;
         fwd_row_ff          <= next_row;
         rsp_pressure_out_ff <= y;
         rsp_saturated_ff    <= sat;
      end
   end

   // The memory read for an item can overlap the write of the item ahead of it,
   // so the newest row written is always checked first.
   assign fwd_hit  = fwd_valid_ff && (fwd_patch_ff == s1_patch_ff);
   assign hist_row = fwd_hit ? fwd_row_ff : ram_rd_data;

   ppf_filter #(
      .ORDER (ORDER)
   ) u_filter (
      .restart  (s1_restart_ff),
      .x        (s1_x_ff),
      .hist_row (hist_row),
      .coefs    (coefs),
      .y        (y),
      .sat      (sat),
      .next_row (next_row)
   );

   assign ram_wr_en   = clr_busy_ff || s1_fire;
   assign ram_wr_addr = clr_busy_ff ? clr_addr_ff : s1_patch_ff;
   assign ram_wr_data = clr_busy_ff ? '0 : next_row;

   ppf_ram #(
      .WIDTH (RowW),
      .DEPTH (PATCHES)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_patch),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pressure_out = rsp_pressure_out_ff;
   assign rsp_saturated    = rsp_saturated_ff;

endmodule

// ===== rtl/ppf_checker.sv =====
module ppf_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [ppf_pkg::SampleW-1:0]        rsp_pressure_out,
   input logic                               rsp_saturated
);

   logic [1:0] items_ff, items_in;
   logic       in_fire;
   logic       out_fire;

   assign in_fire  = req_valid && req_ready;
   assign out_fire = rsp_valid && rsp_ready;
   assign items_in = items_ff + 2'(in_fire) - 2'(out_fire);

   // Items accepted whose results are not yet taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         items_ff <= '0;
      end else begin
         items_ff <= items_in;
      end
   end

   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> items_ff != 2'd0)
      else $error("result shown with no item in flight");

   a_capacity_two: assert property (@(posedge clock) disable iff (reset)
      (items_ff == 2'd2) && !rsp_ready |-> !req_ready)
      else $error("item accepted while both stages are full and stalled");

   a_saturation_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_pressure_out == ppf_pkg::SampleMax) ||
         (rsp_pressure_out == ppf_pkg::SampleMin))
      else $error("saturated result is not a range limit");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_pressure_out) && $stable(rsp_saturated))
      else $error("stalled result changed");

endmodule

bind per_patch_iir_pressure_filter_core ppf_checker u_ppf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_pressure_out (rsp_pressure_out),
   .rsp_saturated    (rsp_saturated)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int NumPhases     = 8;
   localparam int ItemsPerPhase = 244;
   localparam int SteadyPhase   = 5;
   localparam int RegPastEnd    = ppf_pkg::NumRegs;
   localparam int IdlePercent   = 33;
   localparam int ReportLimit   = 10;

   localparam logic signed [79:0] RoundHalf = 80'sd134217728;
   localparam logic signed [79:0] OutMax    = 80'sd2147483647;
   localparam logic signed [79:0] OutMin    = -80'sd2147483648;

   typedef enum logic {StepItem, StepWrite} step_kind_type;
   typedef enum logic [1:0] {MixGentle, MixFull, MixExtreme, MixZero} coef_mix_type;

   typedef struct packed {
      step_kind_type kind;
      logic [2:0]    reg_sel;
      logic [63:0]   wdata;
      logic [7:0]    patch;
      logic [31:0]   pressure;
      logic          restart;
      logic          typed;
      logic [31:0]   want_out;
      logic          want_sat;
   } step_type;

   typedef struct packed {
      logic [ppf_pkg::SampleW-1:0] pressure;
      logic                        saturated;
   } filter_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [ppf_pkg::PatchIndexW-1:0]   req_patch_index = '0;
   logic signed [ppf_pkg::SampleW-1:0] req_pressure_in = '0;
   logic                              req_restart = 1'b0;

   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [ppf_pkg::SampleW-1:0] rsp_pressure_out;
   logic                              rsp_saturated;

   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [ppf_pkg::CsrAddrW-1:0]      csr_paddr = '0;
   logic [ppf_pkg::RegW-1:0]          csr_pwdata = '0;
   logic [ppf_pkg::RegW-1:0]          csr_prdata;
   logic                              csr_pready;

   // Own copy of the coefficient registers and of every patch's histories.
   logic [ppf_pkg::RegW-1:0]           coef_regs [ppf_pkg::NumRegs];
   logic signed [ppf_pkg::SampleW-1:0]
      x_hist [ppf_pkg::DefaultPatches][ppf_pkg::DefaultOrder];
   logic signed [ppf_pkg::SampleW-1:0]
      y_hist [ppf_pkg::DefaultPatches][ppf_pkg::DefaultOrder];

   filter_result_type pending_filter_outputs [$];
   filter_result_type oldest_output;
   int                wrong_results = 0;
   logic              steady = 1'b0;

   per_patch_iir_pressure_filter_core dut (.*);

   always #1 clock = ~clock;

   initial begin
      #400000;
      $display("per_patch_iir_pressure_filter_core: mismatch");
      $finish;
   end

   // Coefficient n: 0..4 are b0..b4, 5..8 are a1..a4.
   function automatic logic signed [ppf_pkg::CoefW-1:0] coef_value(input int n);
      logic [ppf_pkg::RegW-1:0] r;
      r = coef_regs[n >> 1];
      return (n & 1) ? r[63:32] : r[31:0];
   endfunction

   function automatic filter_result_type filter_sample(input logic [7:0] patch,
                                                       input logic signed [31:0] x,
                                                       input logic restart);
      logic signed [79:0] acc;
      logic signed [79:0] y_wide;
      filter_result_type res;
      if (restart) begin
         for (int k = 0; k < ppf_pkg::DefaultOrder; k++) begin
            x_hist[patch][k] = '0;
            y_hist[patch][k] = '0;
         end
      end
      acc = coef_value(0) * x;
      for (int k = 0; k < ppf_pkg::DefaultOrder; k++) begin
         acc = acc + coef_value(k + 1) * x_hist[patch][k]
                   - coef_value(k + ppf_pkg::FeedbackBase) * y_hist[patch][k];
      end
      y_wide = (acc + RoundHalf) >>> ppf_pkg::FracShift;
      res.saturated = (y_wide > OutMax) || (y_wide < OutMin);
      if (y_wide > OutMax) begin
         res.pressure = ppf_pkg::SampleMax;
      end else if (y_wide < OutMin) begin
         res.pressure = ppf_pkg::SampleMin;
      end else begin
         res.pressure = y_wide[31:0];
      end
      for (int k = ppf_pkg::DefaultOrder - 1; k > 0; k--) begin
         x_hist[patch][k] = x_hist[patch][k-1];
         y_hist[patch][k] = y_hist[patch][k-1];
      end
      x_hist[patch][0] = x;
      y_hist[patch][0] = res.pressure;
      return res;
   endfunction

   function automatic logic [31:0] pick_coef(input coef_mix_type mix);
      logic [31:0] r;
      r = $urandom;
      case (mix)
         MixGentle:  return {{5{r[26]}}, r[26:0]};
         MixFull:    return r;
         MixExtreme: return r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
         default:    return 32'h0;
      endcase
   endfunction

   function automatic logic [31:0] pick_pressure();
      logic [31:0] r;
      int          c;
      r = $urandom;
      c = $urandom_range(9);
      if (c < 5) return r;
      if (c < 8) return {{11{r[20]}}, r[20:0]};
      case (r[1:0])
         2'd0:    return 32'h7FFF_FFFF;
         2'd1:    return 32'h8000_0000;
         2'd2:    return 32'h0;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   task automatic send_item(input logic [7:0] patch, input logic [31:0] x,
                            input logic restart, input logic typed,
                            input logic [31:0] want_out, input logic want_sat);
      filter_result_type res;
      @(negedge clock);
      while (!steady && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_patch_index <= patch;
      req_pressure_in <= x;
      req_restart     <= restart;
      do @(posedge clock); while (!req_ready);
      res = filter_sample(patch, x, restart);
      if (typed) begin
         res.pressure  = want_out;
         res.saturated = want_sat;
      end
      pending_filter_outputs.push_back(res);
   endtask

   // Stops the item stream and waits until every result is back, so that
   // the coefficients can be changed with the block idle.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_filter_outputs.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_coef_reg(input int sel, input logic [ppf_pkg::RegW-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ppf_pkg::CsrAddrW'(sel << ppf_pkg::RegSelLsb);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (sel < ppf_pkg::NumRegs) begin
         coef_regs[sel] = (sel == int'(ppf_pkg::RegA4)) ? {32'h0, value[31:0]} : value;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IdlePercent);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_filter_outputs.size() == 0) begin
            wrong_results++;
            if (wrong_results <= ReportLimit)
               $display("unexpected item: pressure_out %h saturated %b",
                        rsp_pressure_out, rsp_saturated);
         end else begin
            oldest_output = pending_filter_outputs.pop_front();
            if (rsp_pressure_out !== oldest_output.pressure ||
                rsp_saturated !== oldest_output.saturated) begin
               wrong_results++;
               if (wrong_results <= ReportLimit)
                  $display("wrong item: expected %h/%b, got %h/%b",
                           oldest_output.pressure, oldest_output.saturated,
                           rsp_pressure_out, rsp_saturated);
            end
         end
      end
   end

   // Under the reset coefficients the output equals the input, and with b0 at
   // its largest value any full-scale sample clips.
   step_type directed_steps [27] = '{
      '{StepItem,  3'd0, 64'h0, 8'h00, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
      '{StepItem,  3'd0, 64'h0, 8'hFF, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b0},
      '{StepItem,  3'd0, 64'h0, 8'hFF, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b0},
      '{StepItem,  3'd0, 64'h0, 8'hFF, 32'h0000_0001, 1'b0, 1'b1, 32'h0000_0001, 1'b0},
      '{StepItem,  3'd0, 64'h0, 8'h00, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{StepItem,  3'd0, 64'h0, 8'hAA, 32'h5555_5555, 1'b0, 1'b1, 32'h5555_5555, 1'b0},
      '{StepItem,  3'd0, 64'h0, 8'h55, 32'hAAAA_AAAA, 1'b1, 1'b1, 32'hAAAA_AAAA, 1'b0},
      '{StepWrite, ppf_pkg::RegB0B1, 64'h0000_0000_7FFF_FFFF, 8'h0, 32'h0, 1'b0, 1'b0,
        32'h0, 1'b0},
      '{StepItem,  3'd0, 64'h0, 8'h03, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1},
      '{StepItem,  3'd0, 64'h0, 8'h03, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000, 1'b1},
      '{StepItem,  3'd0, 64'h0, 8'h03, 32'h0001_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{StepWrite, 3'(RegPastEnd), 64'hFFFF_FFFF_FFFF_FFFF, 8'h0, 32'h0, 1'b0, 1'b0,
        32'h0, 1'b0},
      '{StepWrite, ppf_pkg::RegB2B3, 64'h8000_0000_7FFF_FFFF, 8'h0, 32'h0, 1'b0, 1'b0,
        32'h0, 1'b0},
      '{StepWrite, ppf_pkg::RegB4A1, 64'hF000_0000_8000_0000, 8'h0, 32'h0, 1'b0, 1'b0,
        32'h0, 1'b0},
      '{StepWrite, ppf_pkg::RegA2A3, 64'h7FFF_FFFF_1000_0000, 8'h0, 32'h0, 1'b0, 1'b0,
        32'h0, 1'b0},
      '{StepWrite, ppf_pkg::RegA4,   64'hFFFF_FFFF_8000_0000, 8'h0, 32'h0, 1'b0, 1'b0,
        32'h0, 1'b0},
      '{StepItem,  3'd0, 64'h0, 8'h07, 32'h0001_0000, 1'b1, 1'b0, 32'h0, 1'b0},
      '{StepItem,  3'd0, 64'h0, 8'h07, 32'hFFFF_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{StepItem,  3'd0, 64'h0, 8'h07, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{StepItem,  3'd0, 64'h0, 8'h07, 32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{StepItem,  3'd0, 64'h0, 8'h08, 32'h1234_5678, 1'b1, 1'b0, 32'h0, 1'b0},
      '{StepItem,  3'd0, 64'h0, 8'h07, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 1'b0},
      '{StepWrite, ppf_pkg::RegB0B1, 64'hF800_0000_0800_0000, 8'h0, 32'h0, 1'b0, 1'b0,
        32'h0, 1'b0},
      '{StepWrite, ppf_pkg::RegB4A1, 64'h0800_0000_0000_0000, 8'h0, 32'h0, 1'b0, 1'b0,
        32'h0, 1'b0},
      '{StepItem,  3'd0, 64'h0, 8'h07, 32'h0001_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{StepItem,  3'd0, 64'h0, 8'h07, 32'h0003_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{StepItem,  3'd0, 64'h0, 8'h09, 32'hFFFE_0000, 1'b1, 1'b0, 32'h0, 1'b0}
   };

   coef_mix_type phase_mix [NumPhases] = '{
      MixGentle, MixFull, MixExtreme, MixGentle, MixZero, MixGentle, MixFull, MixGentle
   };

   initial begin
      logic [7:0] hot_patches [3];
      logic [7:0] patch;
      for (int p = 0; p < ppf_pkg::DefaultPatches; p++) begin
         for (int k = 0; k < ppf_pkg::DefaultOrder; k++) begin
            x_hist[p][k] = '0;
            y_hist[p][k] = '0;
         end
      end
      for (int r = 0; r < ppf_pkg::NumRegs; r++) coef_regs[r] = ppf_pkg::RegReset[r];

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == StepWrite) begin
            drain_results();
            write_coef_reg(int'(directed_steps[i].reg_sel), directed_steps[i].wdata);
         end else begin
            send_item(directed_steps[i].patch, directed_steps[i].pressure,
                      directed_steps[i].restart, directed_steps[i].typed,
                      directed_steps[i].want_out, directed_steps[i].want_sat);
         end
      end

      for (int phase = 0; phase < NumPhases; phase++) begin
         drain_results();
         steady = (phase == SteadyPhase);
         for (int r = 0; r < ppf_pkg::NumRegs; r++) begin
            write_coef_reg(r, {pick_coef(phase_mix[phase]), pick_coef(phase_mix[phase])});
         end
         if ($urandom_range(2) == 0)
            write_coef_reg(RegPastEnd + int'($urandom_range(2)), {$urandom, $urandom});
         foreach (hot_patches[h]) hot_patches[h] = 8'($urandom_range(255));
         // Most items hit a few patches so that back-to-back samples on one
         // patch exercise the history forwarding.
         for (int n = 0; n < ItemsPerPhase; n++) begin
            if ($urandom_range(99) < 70)
               patch = hot_patches[$urandom_range(2)];
            else
               patch = 8'($urandom_range(255));
            send_item(patch, pick_pressure(), $urandom_range(99) < 4, 1'b0, 32'h0, 1'b0);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (wrong_results == 0) begin
         $display("per_patch_iir_pressure_filter_core: match");
      end else begin
         $display("per_patch_iir_pressure_filter_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ppf_pkg.sv
rtl/ppf_ram.sv
rtl/ppf_regs.sv
rtl/ppf_filter.sv
rtl/per_patch_iir_pressure_filter_core.sv
rtl/ppf_checker.sv
tb/sv/testbench.sv
